### hdl/hctb_pkg.sv
`timescale 1ns / 1ps

package hctb_pkg;

  // Default sizes of the block.
  localparam int SYMBOLS_DEF       = 256;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int MAX_CODE_BITS_DEF = 63;

  // Fixed field widths of the result.
  localparam int CODE_W = 64;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // Commands carried on the input side band.
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_DATA   = 2'd1,
    STAT_SATURATED = 2'd2,
    STAT_NOT_BUILT = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD,
    S_PREP,
    S_SCAN,
    S_SCAN_LAST,
    S_PICK,
    S_T_RD,
    S_T_A,
    S_T_B
  } state_t;

  // Control of the shared minimum unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

### hdl/hctb_min.sv
`timescale 1ns / 1ps

module hctb_min
  import hctb_pkg::*;
#(
  parameter int W  = COUNT_BITS_DEF,
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  scan_ctl_t     ctl,
  input  logic [W-1:0]  weight,
  input  logic [IW-1:0] index,
  output logic          found,
  output logic [W-1:0]  best_w,
  output logic [IW-1:0] best_i
);

  logic take;

  // A strictly smaller weight replaces the best, so ties keep the earliest index.
  assign take = ctl.sample && (!found || (weight < best_w));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_w <= weight;
      best_i <= index;
    end
  end

endmodule

### hdl/huffman_code_table_builder_core.sv
`timescale 1ns / 1ps
// Huffman code table builder for a byte alphabet.
// Input beats arrive on s_axis: tuser carries the command (count byte, build
// codes, read code, clear histogram) and tdata carries the byte or symbol.
// Every input beat yields exactly one output beat on m_axis with the code
// bits, code length, presence flag and status.
// Count, query and clear commands pass through the execute state: the
// histogram and code table are read at the accepting edge, the update or
// lookup runs in the next cycle, and the result is then registered in the
// output register, or in the hold register while the receiver stalls.
// A build makes one pass over the valid bits to find the present symbols,
// every pick scans the histogram memory once through the single shared
// minimum unit, and the code assignment walks the merged nodes through
// S_T_RD, S_T_A and S_T_B for each node.
// One command is worked on at a time; s_axis_tready is high only while the
// sequencer is idle. The output register lets a new command be accepted
// while the previous result beat still waits. If the receiver stalls when
// a result is ready, the sequencer holds that result until the output
// register frees up.
// Reset clears the histogram (per-entry valid bits), the total, the
// saturation flag and the built state; no clearing pass is needed.

module huffman_code_table_builder_core
  import hctb_pkg::*;
#(
  parameter int SYMBOLS       = SYMBOLS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [63:0] code_bits, [69:64] code_length,
                                      // [70] symbol_present, [72:71] status
);

  localparam int SW  = $clog2(SYMBOLS);
  localparam int IW  = $clog2(2 * SYMBOLS - 1);
  localparam int MIW = (SYMBOLS > 2) ? $clog2(SYMBOLS - 1) : 1;
  localparam int DW  = SW;
  localparam int PW  = SW + 2;
  localparam int TW  = LEN_W + CODE_W;
  localparam int NW  = DW + CODE_W;

  state_t state, state_next;

  // Latched command.
  op_t              op_r;
  logic [BYTE_W-1:0] sym_r;
  logic             in_rng_r;

  // Histogram.
  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0]    cnt_v;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  cnt_vr;
  logic [SW-1:0]         cnt_addr;
  logic [COUNT_BITS-1:0] cnt_val;
  logic                  cnt_we;

  logic [COUNT_BITS-1:0] total;
  logic                  sat;
  logic                  codes_ready;
  logic                  too_long;
  logic                  sat_now;
  logic                  in_acc;
  logic                  in_rng;

  // Build working state.
  logic [SYMBOLS-1:0]    leaf_q;
  logic [SW:0]           idx;
  logic [SW:0]           present;
  logic [SW:0]           present_next;
  logic [SW-1:0]         last_sym;
  logic [SW-1:0]         lone_sym;
  logic                  s_v;
  logic [SW-1:0]         s_i;
  logic [MIW:0]          m;
  logic [MIW:0]          h;
  logic                  sel_j;
  logic [IW-1:0]         pick0;
  logic [COUNT_BITS-1:0] pw0;
  logic [MIW-1:0]        t;
  logic                  scan_end;

  // Merged node storage.
  logic [COUNT_BITS-1:0] mw_mem [SYMBOLS-1];
  logic [2*IW-1:0]       ch_mem [SYMBOLS-1];
  logic [NW-1:0]         dc_mem [SYMBOLS-1];
  logic [COUNT_BITS-1:0] mw_rd;
  logic [2*IW-1:0]       ch_rd;
  logic [NW-1:0]         dc_rd;

  // Code table.
  logic [TW-1:0] tbl_mem [SYMBOLS];
  logic [TW-1:0] tbl_rd;
  logic          tbl_we;
  logic [SW-1:0] tbl_wa;
  logic [TW-1:0] tbl_wd;

  // Minimum unit.
  scan_ctl_t             sctl;
  logic                  best_found;
  logic [COUNT_BITS-1:0] best_w;
  logic [SW-1:0]         best_i;

  // Pick selection.
  logic                  m_av;
  logic                  use_leaf;
  logic [IW-1:0]         sel_idx;
  logic [COUNT_BITS-1:0] sel_w;
  logic                  merges_done;

  // Tree walk.
  logic              is_root;
  logic [DW-1:0]     nd;
  logic [CODE_W-1:0] ncode;
  logic [IW-1:0]     child;
  logic [IW-1:0]     child_off;
  logic [CODE_W-1:0] ccode;
  logic [DW-1:0]     cd;
  logic              child_leaf;
  logic              child_long;
  logic              dc_we;
  logic              walk;

  // Results.
  logic              done;
  logic              out_free;
  logic [CODE_W-1:0] res_bits;
  logic [LEN_W-1:0]  res_len;
  logic              res_pres;
  status_t           res_stat;
  logic [CODE_W-1:0] r_bits;
  logic [LEN_W-1:0]  r_len;
  logic              r_pres;
  status_t           r_stat;
  logic [CODE_W-1:0] o_bits;
  logic [LEN_W-1:0]  o_len;
  logic              o_pres;
  status_t           o_stat;
  logic              m_valid;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_rng        = ({1'b0, s_axis_tdata} < 9'(SYMBOLS));
  assign out_free      = !m_valid || m_axis_tready;
  assign sat_now       = (total == {COUNT_BITS{1'b1}});
  assign cnt_val       = cnt_vr ? cnt_rd : '0;
  assign cnt_addr      = (state == S_IDLE) ? s_axis_tdata[SW-1:0] : idx[SW-1:0];
  assign scan_end      = (idx == (SW+1)'(SYMBOLS - 1));
  assign present_next  = present + (SW+1)'(cnt_v[idx[SW-1:0]]);
  assign lone_sym      = cnt_v[idx[SW-1:0]] ? idx[SW-1:0] : last_sym;

  // Pick between the best queued leaf and the head of the merged queue.
  assign m_av        = (h < m);
  assign use_leaf    = best_found && (!m_av || (best_w <= mw_rd));
  assign sel_idx     = use_leaf ? IW'(best_i) : IW'(SYMBOLS) + IW'(h);
  assign sel_w       = use_leaf ? best_w : mw_rd;
  assign merges_done = (PW'(m) + PW'(1)) == (PW'(present) - PW'(1));

  // Child of the current node in the tree walk.
  assign walk       = (state == S_T_A) || (state == S_T_B);
  assign is_root    = (PW'(t) + PW'(1)) == PW'(m);
  assign nd         = is_root ? '0 : dc_rd[NW-1:CODE_W];
  assign ncode      = is_root ? '0 : dc_rd[CODE_W-1:0];
  assign child      = (state == S_T_A) ? ch_rd[IW-1:0] : ch_rd[2*IW-1:IW];
  assign ccode      = (state == S_T_A) ? ncode : (ncode | (CODE_W'(1) << nd));
  assign cd         = nd + DW'(1);
  assign child_leaf = (child < IW'(SYMBOLS));
  assign child_long = child_leaf && (32'(cd) > MAX_CODE_BITS);
  assign child_off  = child - IW'(SYMBOLS);
  assign dc_we      = walk && !child_leaf;

  // Code table write port: lone symbol or a leaf reached by the walk.
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = child[SW-1:0];
    tbl_wd = {LEN_W'(cd), ccode};
    if (walk && child_leaf) begin
      tbl_we = 1'b1;
    end else if ((state == S_PREP) && scan_end && (present_next == (SW+1)'(1))) begin
      tbl_we = 1'b1;
      tbl_wa = lone_sym;
      tbl_wd = {LEN_W'(1), {CODE_W{1'b0}}};
    end
  end

  assign cnt_we = (state == S_EXEC) && (op_r == OP_COUNT) && in_rng_r && !sat_now;

  assign sctl.sample = s_v;
  assign sctl.clear  = (state_next == S_SCAN) && (state != S_SCAN);

  hctb_min #(
    .W  (COUNT_BITS),
    .IW (SW)
  ) u_min (
    .clk    (clk),
    .rst    (rst),
    .ctl    (sctl),
    .weight (cnt_rd),
    .index  (s_i),
    .found  (best_found),
    .best_w (best_w),
    .best_i (best_i)
  );

  // Sequencer: next state and result.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    res_bits   = '0;
    res_len    = '0;
    res_pres   = 1'b0;
    res_stat   = sat ? STAT_SATURATED : STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_COUNT: begin
            done     = 1'b1;
            res_stat = (sat || (in_rng_r && sat_now)) ? STAT_SATURATED : STAT_OK;
          end
          OP_CLEAR: begin
            done     = 1'b1;
            res_stat = STAT_OK;
          end
          OP_QUERY: begin
            done     = 1'b1;
            res_pres = in_rng_r && (cnt_val != '0);
            if (codes_ready && res_pres) begin
              res_bits = tbl_rd[CODE_W-1:0];
              res_len  = tbl_rd[TW-1:CODE_W];
            end
            if (!codes_ready) begin
              res_stat = STAT_NOT_BUILT;
            end
          end
          OP_BUILD: begin
            if (total == '0) begin
              done     = 1'b1;
              res_stat = STAT_NO_DATA;
            end else begin
              state_next = S_PREP;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_PREP: begin
        if (scan_end) begin
          if (present_next == (SW+1)'(1)) begin
            done = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = (sel_j && merges_done) ? S_T_RD : S_SCAN;
      end
      S_T_RD: begin
        state_next = S_T_A;
      end
      S_T_A: begin
        state_next = S_T_B;
      end
      S_T_B: begin
        if (t == '0) begin
          done = 1'b1;
          if (too_long || child_long) begin
            res_stat = STAT_SATURATED;
          end
        end else begin
          state_next = S_T_RD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (done) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: histogram valid bits, total, flags, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_v       <= '0;
      total       <= '0;
      sat         <= 1'b0;
      codes_ready <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      if (state == S_EXEC) begin
        unique case (op_r)
          OP_COUNT: begin
            codes_ready <= 1'b0;
            if (in_rng_r && sat_now) begin
              sat <= 1'b1;
            end
            if (cnt_we) begin
              cnt_v[sym_r[SW-1:0]] <= 1'b1;
              total                <= total + COUNT_BITS'(1);
            end
          end
          OP_CLEAR: begin
            cnt_v       <= '0;
            total       <= '0;
            sat         <= 1'b0;
            codes_ready <= 1'b0;
          end
          OP_BUILD: begin
            codes_ready <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (done && (state != S_EXEC) && !((state == S_T_B) && (too_long || child_long))) begin
        codes_ready <= 1'b1;
      end
      if ((done && out_free) || ((state == S_HOLD) && out_free)) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Command latch, build counters and result registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_t'(s_axis_tuser);
      sym_r    <= s_axis_tdata;
      in_rng_r <= in_rng;
    end
    s_v <= (state == S_SCAN) && leaf_q[idx[SW-1:0]];
    s_i <= idx[SW-1:0];
    unique case (state)
      S_EXEC: begin
        idx      <= '0;
        present  <= '0;
        m        <= '0;
        h        <= '0;
        sel_j    <= 1'b0;
        too_long <= 1'b0;
      end
      S_PREP: begin
        leaf_q[idx[SW-1:0]] <= cnt_v[idx[SW-1:0]];
        present             <= present_next;
        last_sym            <= lone_sym;
        idx                 <= scan_end ? '0 : idx + (SW+1)'(1);
      end
      S_SCAN: begin
        if (!scan_end) begin
          idx <= idx + (SW+1)'(1);
        end
      end
      S_PICK: begin
        idx <= '0;
        if (use_leaf) begin
          leaf_q[best_i] <= 1'b0;
        end else begin
          h <= h + (MIW+1)'(1);
        end
        if (!sel_j) begin
          pick0 <= sel_idx;
          pw0   <= sel_w;
          sel_j <= 1'b1;
        end else begin
          sel_j <= 1'b0;
          m     <= m + (MIW+1)'(1);
          t     <= m[MIW-1:0];
        end
      end
      S_T_A: begin
        if (child_long) begin
          too_long <= 1'b1;
        end
      end
      S_T_B: begin
        if (child_long) begin
          too_long <= 1'b1;
        end
        if (t != '0) begin
          t <= t - MIW'(1);
        end
      end
      default: begin
      end
    endcase
    if (done && !out_free) begin
      r_bits <= res_bits;
      r_len  <= res_len;
      r_pres <= res_pres;
      r_stat <= res_stat;
    end
    if (done && out_free) begin
      o_bits <= res_bits;
      o_len  <= res_len;
      o_pres <= res_pres;
      o_stat <= res_stat;
    end else if ((state == S_HOLD) && out_free) begin
      o_bits <= r_bits;
      o_len  <= r_len;
      o_pres <= r_pres;
      o_stat <= r_stat;
    end
  end

  // Histogram memory.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[sym_r[SW-1:0]] <= cnt_val + COUNT_BITS'(1);
    end
    cnt_rd <= cnt_mem[cnt_addr];
    cnt_vr <= cnt_v[cnt_addr];
  end

  // Merged node memories.
  always_ff @(posedge clk) begin
    if ((state == S_PICK) && sel_j) begin
      mw_mem[m[MIW-1:0]] <= pw0 + sel_w;
      ch_mem[m[MIW-1:0]] <= {sel_idx, pick0};
    end
    if (dc_we) begin
      dc_mem[child_off[MIW-1:0]] <= {cd, ccode};
    end
    mw_rd <= mw_mem[h[MIW-1:0]];
    ch_rd <= ch_mem[t];
    dc_rd <= dc_mem[t];
  end

  // Code table memory.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd <= tbl_mem[cnt_addr];
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'd0, o_stat, o_pres, o_len, o_bits};

  // Built codes always rest on counted data.
  a_ready_has_data: assert property (@(posedge clk) disable iff (rst)
    codes_ready |-> (total != '0))
    else $error("codes marked ready with an empty histogram");

  // The merged queue head never passes the number of merged nodes.
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (h <= m))
    else $error("merged queue head ran past the merged nodes");

  // One command at a time: an accepted beat is never followed by another at once.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a command is in progress");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hctb_pkg::*;

  localparam int NSYM       = 256;
  localparam int NODES      = 2 * NSYM - 1;
  localparam int IDLE_LIMIT = 600000;
  localparam int HOLD_LEN   = 3000;

  // One predicted result beat.
  typedef struct {
    logic [63:0] code;
    logic [5:0]  len;
    logic        present;
    status_t     status;
  } code_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // [63:0] code_bits, [69:64] code_length,
                                    // [70] symbol_present, [72:71] status

  huffman_code_table_builder_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Predicted block state.
  longint unsigned hist[NSYM];
  longint unsigned hist_total;
  logic [63:0]     tbl_code[NSYM];
  logic [5:0]      tbl_len[NSYM];
  bit              tbl_ready;
  bit              sat_seen;

  code_result_t pending_q[$];
  int  errors = 0;
  int  burst_left = 0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  // Runs the merge walk on the histogram and fills the code table.
  function automatic status_t build_table();
    longint unsigned wt[NODES];
    bit              queued[NODES];
    int              kid_a[NODES];
    int              kid_b[NODES];
    int              dep[NODES];
    logic [63:0]     cd[NODES];
    int              present = 0;
    int              merged = 0;
    int              pick[2];
    int              best;
    int              p;
    bit              too_long = 1'b0;
    for (int i = 0; i < NSYM; i++) begin
      tbl_code[i] = '0;
      tbl_len[i] = '0;
    end
    tbl_ready = 1'b0;
    if (hist_total == 0) return STAT_NO_DATA;
    for (int i = 0; i < NODES; i++) begin
      queued[i] = 1'b0;
      dep[i] = 0;
      cd[i] = '0;
      wt[i] = 0;
    end
    for (int i = 0; i < NSYM; i++) begin
      if (hist[i] != 0) begin
        wt[i] = hist[i];
        queued[i] = 1'b1;
        present++;
      end
    end
    if (present == 1) begin
      for (int i = 0; i < NSYM; i++)
        if (hist[i] != 0) tbl_len[i] = 6'd1;
    end else begin
      for (int k = 0; k + 1 < present; k++) begin
        // Take the two lightest nodes; ties go to the lowest index.
        for (int j = 0; j < 2; j++) begin
          best = -1;
          for (int n = 0; n < NSYM + merged; n++)
            if (queued[n] && (best < 0 || wt[n] < wt[best])) best = n;
          queued[best] = 1'b0;
          pick[j] = best;
        end
        p = NSYM + merged;
        wt[p] = wt[pick[0]] + wt[pick[1]];
        kid_a[p] = pick[0];
        kid_b[p] = pick[1];
        queued[p] = 1'b1;
        merged++;
      end
      // Walk from the root down; parents come after their children.
      for (int k = merged; k > 0; k--) begin
        p = NSYM + k - 1;
        dep[kid_a[p]] = dep[p] + 1;
        dep[kid_b[p]] = dep[p] + 1;
        cd[kid_a[p]] = cd[p];
        cd[kid_b[p]] = cd[p] | ((dep[p] < 64) ? (64'd1 << dep[p]) : 64'd0);
      end
      for (int i = 0; i < NSYM; i++) begin
        if (hist[i] != 0) begin
          if (dep[i] > 63) too_long = 1'b1;
          tbl_len[i] = dep[i][5:0];
          tbl_code[i] = cd[i];
        end
      end
      if (too_long) begin
        for (int i = 0; i < NSYM; i++) begin
          tbl_code[i] = '0;
          tbl_len[i] = '0;
        end
        return STAT_SATURATED;
      end
    end
    tbl_ready = 1'b1;
    return sat_seen ? STAT_SATURATED : STAT_OK;
  endfunction

  // Applies one accepted command to the predicted state.
  function automatic code_result_t predict_command(op_t op, logic [7:0] sym);
    code_result_t r;
    r.code = '0;
    r.len = '0;
    r.present = 1'b0;
    r.status = STAT_OK;
    case (op)
      OP_COUNT: begin
        tbl_ready = 1'b0;
        if (hist_total >= 64'hFFFF_FFFF) sat_seen = 1'b1;
        else begin
          hist[sym]++;
          hist_total++;
        end
        r.status = sat_seen ? STAT_SATURATED : STAT_OK;
      end
      OP_BUILD: r.status = build_table();
      OP_QUERY: begin
        r.present = hist[sym] != 0;
        if (tbl_ready) begin
          r.code = tbl_code[sym];
          r.len = tbl_len[sym];
        end
        r.status = !tbl_ready ? STAT_NOT_BUILT : (sat_seen ? STAT_SATURATED : STAT_OK);
      end
      default: begin
        for (int i = 0; i < NSYM; i++) begin
          hist[i] = 0;
          tbl_code[i] = '0;
          tbl_len[i] = '0;
        end
        hist_total = 0;
        tbl_ready = 1'b0;
        sat_seen = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Sends one command beat, with random gaps between bursts.
  task automatic send_command(op_t op, logic [7:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= sym;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_q.push_back(predict_command(op, sym));
  endtask

  // Stops offering beats and waits for every predicted result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_command(OP_QUERY, 8'd0);       // nothing counted, nothing built
    send_command(OP_BUILD, 8'd0);       // build on an empty histogram
    send_command(OP_COUNT, 8'hFF);      // a lone symbol
    send_command(OP_BUILD, 8'd0);
    send_command(OP_QUERY, 8'hFF);
    send_command(OP_QUERY, 8'h00);
    send_command(OP_COUNT, 8'h00);      // counting drops the built table
    send_command(OP_QUERY, 8'hFF);
    send_command(OP_BUILD, 8'd0);       // two equal weights
    send_command(OP_QUERY, 8'h00);
    send_command(OP_QUERY, 8'hFF);
    send_command(OP_COUNT, 8'h55);
    send_command(OP_COUNT, 8'hAA);
    send_command(OP_COUNT, 8'hAA);      // ties between leaves and merged nodes
    send_command(OP_BUILD, 8'd0);
    send_command(OP_QUERY, 8'h55);
    send_command(OP_QUERY, 8'hAA);
    send_command(OP_QUERY, 8'h00);
    send_command(OP_CLEAR, 8'hFF);
    send_command(OP_QUERY, 8'hAA);
    send_command(OP_BUILD, 8'd0);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps going.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_command(i % 5 == 4 ? OP_QUERY : OP_COUNT, 8'($urandom_range(0, 255)));
    send_command(OP_BUILD, 8'd0);
    while (hold_req) @(posedge clk);
    drain_results();
  endtask

  // Every symbol present, symbol 7 twice: the largest tree the block supports.
  task automatic test_full_alphabet();
    send_command(OP_CLEAR, 8'd0);
    for (int i = 0; i < NSYM; i++) send_command(OP_COUNT, 8'(i));
    send_command(OP_COUNT, 8'd7);
    send_command(OP_BUILD, 8'd0);
    for (int i = 0; i < 12; i++) send_command(OP_QUERY, 8'($urandom_range(0, 255)));
    send_command(OP_QUERY, 8'd0);
    send_command(OP_QUERY, 8'd255);
    drain_results();
  endtask

  // Count, build and read sequences over small random symbol sets.
  task automatic test_random();
    logic [7:0] set[$];
    int sent = 0;
    int nsym;
    int nbytes;
    while (sent < 100) begin
      if ($urandom_range(0, 5) == 0) begin
        send_command(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        sent++;
        continue;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_command(OP_CLEAR, 8'($urandom_range(0, 255)));
        sent++;
      end
      set.delete();
      nsym = $urandom_range(1, 10);
      for (int i = 0; i < nsym; i++) set.push_back(8'($urandom_range(0, 255)));
      nbytes = $urandom_range(nsym, 30);
      for (int i = 0; i < nbytes; i++) begin
        // Skew toward the first symbols to get uneven weights.
        send_command(OP_COUNT, set[$urandom_range(0, $urandom_range(0, nsym - 1))]);
        sent++;
      end
      send_command(OP_BUILD, 8'($urandom_range(0, 255)));
      sent++;
      for (int i = 0; i < nsym + 2; i++) begin
        send_command(OP_QUERY, ($urandom_range(0, 3) == 0) ?
                     8'($urandom_range(0, 255)) : set[$urandom_range(0, nsym - 1)]);
        sent++;
      end
    end
    drain_results();
  endtask

  // Receiver stall pattern, with long hold-off on request.
  always @(posedge clk) begin
    int hold_cnt;
    int mode;
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_LEN) begin
        hold_req <= 1'b0;
        hold_cnt = 0;
      end
    end else begin
      mode = $urandom_range(0, 99);
      m_axis_tready <= (mode < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    code_result_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[63:0] !== e.code) begin
          $error("code_bits expected %h got %h", e.code, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[69:64] !== e.len) begin
          $error("code_length expected %0d got %0d", e.len, m_axis_tdata[69:64]);
          errors++;
        end
        if (m_axis_tdata[70] !== e.present) begin
          $error("symbol_present expected %b got %b", e.present, m_axis_tdata[70]);
          errors++;
        end
        if (m_axis_tdata[72:71] !== e.status) begin
          $error("status expected %0d got %0d", e.status, m_axis_tdata[72:71]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSYM; i++) begin
      hist[i] = 0;
      tbl_code[i] = '0;
      tbl_len[i] = '0;
    end
    hist_total = 0;
    tbl_ready = 1'b0;
    sat_seen = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_alphabet();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
hdl/hctb_pkg.sv
hdl/hctb_min.sv
hdl/huffman_code_table_builder_core.sv
bench/testbench.sv
